FILE: rtl/lpht_pkg.sv
package lpht_pkg;

    // Field widths of the stream words and the configuration register.
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    // Packed stream widths, filled up to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // Table geometry and register reset value.
    localparam int           TABLE_SLOTS_DEF = 23;
    localparam logic [4:0]   MAX_PROBES_RST  = 5'd10;

    // Home slot reduction: the first step forms the reciprocal product, the second
    // multiplies the quotient back and subtracts.
    localparam int MOD_STEPS = 2;
    localparam int MOD_CNT_W = 1;

    // Slot status codes held in the status memory.
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_GONE  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } lpht_op_t;

    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } lpht_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_ISSUE,
        ST_PROBE,
        ST_FINISH
    } lpht_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic mod_step;
        logic issue;
        logic probe_step;
        logic finish;
    } lpht_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic probe_stop;
        logic out_free;
    } lpht_stat_t;

endpackage

FILE: rtl/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lpht_ctrl.sv
module lpht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpht_pkg::lpht_stat_t stat,
    output lpht_pkg::lpht_cmd_t  cmd
);

    lpht_pkg::lpht_state_t state_reg;
    lpht_pkg::lpht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            lpht_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lpht_pkg::ST_HOME;
                end
            end
            lpht_pkg::ST_HOME:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = lpht_pkg::ST_ISSUE;
                end
            end
            lpht_pkg::ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = lpht_pkg::ST_PROBE;
            end
            lpht_pkg::ST_PROBE:
            begin
                cmd.probe_step = 1'b1;
                if (stat.probe_stop)
                begin
                    state_next = lpht_pkg::ST_FINISH;
                end
            end
            lpht_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lpht_dp.sv
module lpht_dp #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpht_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [lpht_pkg::OPCODE_W-1:0]  in_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]     in_key,
    input  logic [lpht_pkg::VALUE_W-1:0]   in_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]  out_status,
    output logic [lpht_pkg::VALUE_W-1:0]   out_value,
    input  lpht_pkg::lpht_cmd_t            cmd,
    output lpht_pkg::lpht_stat_t           stat
);

    localparam int PW   = $clog2(TABLE_SLOTS);
    localparam int CW   = $clog2(TABLE_SLOTS + 1);
    localparam int WW   = (CW > lpht_pkg::CFG_W + 1) ? CW : lpht_pkg::CFG_W + 1;
    localparam int KV_W = lpht_pkg::KEY_W + lpht_pkg::VALUE_W;

    // Reciprocal of the table size, rounded up. With the shift set to the key
    // width plus ceil(log2(TABLE_SLOTS)) the truncated product is the exact
    // quotient for every key.
    localparam int RECIP_W = lpht_pkg::KEY_W + 1;
    localparam int PROD_W  = lpht_pkg::KEY_W + RECIP_W;
    localparam int SHIFT   = lpht_pkg::KEY_W + PW;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    // Configuration and the latched input word.
    logic [lpht_pkg::CFG_W-1:0]    max_probes_reg;
    lpht_pkg::lpht_op_t            op_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_reg;
    logic [lpht_pkg::VALUE_W-1:0]  value_reg;

    // Home slot reduction.
    logic [PROD_W-1:0]              prod_reg;
    logic [lpht_pkg::KEY_W-1:0]     quot;
    logic [lpht_pkg::KEY_W-1:0]     rem_wide;
    logic [PW-1:0]                  rem_reg;
    logic [PW-1:0]                  rem_next;
    logic [lpht_pkg::MOD_CNT_W-1:0] mod_cnt_reg;

    // Probe walk; pos_reg also sweeps the status memory after reset.
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_inc;
    logic [WW-1:0] n_reg;
    logic          hit_reg;
    logic [PW-1:0] hit_pos_reg;
    logic [lpht_pkg::VALUE_W-1:0] hit_val_reg;
    logic          free_reg;
    logic [PW-1:0] free_pos_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [lpht_pkg::STATUS_W-1:0] out_status_reg;
    logic [lpht_pkg::VALUE_W-1:0]  out_value_reg;

    // Memory ports.
    logic          st_we;
    logic [PW-1:0] st_waddr;
    logic [1:0]    st_wdata;
    logic [1:0]    st_rdata;
    logic          kv_we;
    logic [PW-1:0] kv_waddr;
    logic [PW-1:0] raddr;
    logic [KV_W-1:0] kv_rdata;

    logic [WW-1:0] win_full;
    logic [WW-1:0] win_last;
    logic          slot_empty;
    logic          slot_used;
    logic          slot_match;
    logic          probe_stop;

    logic [lpht_pkg::STATUS_W-1:0] res_status;
    logic [lpht_pkg::VALUE_W-1:0]  res_value;

    // The quotient never exceeds the key, so the product with the table size
    // and the difference both fit in the key width; the difference is below
    // the table size.
    assign quot     = lpht_pkg::KEY_W'(prod_reg >> SHIFT);
    assign rem_wide = key_reg - quot * lpht_pkg::KEY_W'(TABLE_SLOTS);
    assign rem_next = PW'(rem_wide);

    assign pos_inc = (pos_reg == PW'(TABLE_SLOTS - 1)) ? '0 : pos_reg + PW'(1);
    assign raddr   = cmd.issue ? rem_reg : pos_inc;

    assign win_full   = WW'(max_probes_reg) + WW'(1);
    assign win_last   = ((win_full > WW'(TABLE_SLOTS)) ? WW'(TABLE_SLOTS) : win_full) - WW'(1);
    assign slot_empty = (st_rdata == lpht_pkg::SLOT_EMPTY);
    assign slot_used  = (st_rdata == lpht_pkg::SLOT_USED);
    assign slot_match = slot_used && (kv_rdata[lpht_pkg::KEY_W-1:0] == key_reg);
    assign probe_stop = slot_empty || slot_match || (n_reg == win_last);

    assign stat.clear_last = (pos_reg == PW'(TABLE_SLOTS - 1));
    assign stat.mod_last   = (mod_cnt_reg == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1));
    assign stat.probe_stop = probe_stop;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Result and table updates for the finishing operation, and the status writes of the clearing sweep.
    always_comb
    begin
        res_status = lpht_pkg::RES_MISS;
        res_value  = '0;
        st_we      = 1'b0;
        st_waddr   = pos_reg;
        st_wdata   = lpht_pkg::SLOT_EMPTY;
        kv_we      = 1'b0;
        kv_waddr   = hit_pos_reg;
        if (cmd.clear_step)
        begin
            st_we = 1'b1;
        end
        else if (cmd.finish)
        begin
            unique case (op_reg)
                lpht_pkg::OP_INSERT:
                begin
                    if (hit_reg)
                    begin
                        kv_we      = 1'b1;
                        res_status = lpht_pkg::RES_OK;
                    end
                    else if (free_reg)
                    begin
                        kv_we      = 1'b1;
                        kv_waddr   = free_pos_reg;
                        st_we      = 1'b1;
                        st_waddr   = free_pos_reg;
                        st_wdata   = lpht_pkg::SLOT_USED;
                        res_status = lpht_pkg::RES_OK;
                    end
                    else
                    begin
                        res_status = lpht_pkg::RES_FULL;
                    end
                end
                lpht_pkg::OP_REMOVE:
                begin
                    if (hit_reg)
                    begin
                        st_we      = 1'b1;
                        st_waddr   = hit_pos_reg;
                        st_wdata   = lpht_pkg::SLOT_GONE;
                        res_status = lpht_pkg::RES_OK;
                    end
                end
                lpht_pkg::OP_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        res_status = lpht_pkg::RES_OK;
                        res_value  = hit_val_reg;
                    end
                end
                lpht_pkg::OP_NONE:
                begin
                    res_status = lpht_pkg::RES_MISS;
                end
                default:
                begin
                    res_status = lpht_pkg::RES_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_probes_reg <= lpht_pkg::MAX_PROBES_RST;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mod_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_probes_reg <= cfg_wr_data;
            end
            if (cmd.clear_step && !stat.clear_last)
            begin
                pos_reg <= pos_inc;
            end
            else if (cmd.issue)
            begin
                pos_reg <= rem_reg;
            end
            else if (cmd.probe_step && !probe_stop)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.load)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + lpht_pkg::MOD_CNT_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= lpht_pkg::lpht_op_t'(in_opcode);
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        else if (cmd.mod_step)
        begin
            // First step: key times the reciprocal. Second step: remainder.
            if (stat.mod_last)
            begin
                rem_reg <= rem_next;
            end
            else
            begin
                prod_reg <= PROD_W'(key_reg) * PROD_W'(RECIP);
            end
        end
        if (cmd.issue)
        begin
            n_reg    <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.probe_step)
        begin
            n_reg <= n_reg + WW'(1);
            if (slot_match)
            begin
                hit_reg     <= 1'b1;
                hit_pos_reg <= pos_reg;
                hit_val_reg <= kv_rdata[KV_W-1:lpht_pkg::KEY_W];
            end
            if (!free_reg && !slot_used)
            begin
                free_reg     <= 1'b1;
                free_pos_reg <= pos_reg;
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
        end
    end

    lpht_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_SLOTS)
    ) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    lpht_ram #(
        .WIDTH (KV_W),
        .DEPTH (TABLE_SLOTS)
    ) u_kv_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata ({value_reg, key_reg}),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// Channel   Direction  tdata                          tuser
// s_*       in         key [30:0], value [62:31]      opcode [1:0]
// m_*       out        value_out [31:0]               status [1:0]
// cfg_*     in         max_probes [4:0] (write only)  -
//
// One operation runs from acceptance to a result in the output register in
// order: the key is reduced to its home slot by a reciprocal multiplication,
// the home slot read is issued, the probe walk reads one slot a cycle over P
// slots (1 up to min(max_probes+1, TABLE_SLOTS)), and the result is loaded.
// The next word is taken in the cycle after, so no new word is accepted while
// one is in progress. After reset the status memory is swept to empty, slot by
// slot, and no word is accepted until the sweep is done. A stalled output
// holds the finishing operation until it frees.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration: max_probes, written on every cycle with cfg_wr_en high.
    input  logic                              cfg_wr_en,
    input  logic [lpht_pkg::CFG_W-1:0]        cfg_wr_data,
    // Input word stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpht_pkg::IN_DATA_W-1:0]    s_tdata,   // key [30:0], value [62:31], zero
    input  logic [lpht_pkg::OPCODE_W-1:0]     s_tuser,   // opcode [1:0]
    // Result word stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpht_pkg::OUT_DATA_W-1:0]   m_tdata,   // value_out [31:0]
    output logic [lpht_pkg::STATUS_W-1:0]     m_tuser    // status [1:0]
);

    lpht_pkg::lpht_cmd_t  cmd;
    lpht_pkg::lpht_stat_t stat;

    // The controller sequences the clearing sweep, the home slot reduction,
    // the probe walk and the final update; it sees only the status group and the input valid.
    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the latched word, the remainder unit, the probe
    // registers, both table memories and the output register.
    lpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_opcode   (s_tuser),
        .in_key      (s_tdata[lpht_pkg::KEY_W-1:0]),
        .in_value    (s_tdata[lpht_pkg::KEY_W+lpht_pkg::VALUE_W-1:lpht_pkg::KEY_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_value   (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
